// ===== hw/rtl/qrn_pkg.sv =====
// Shared types, constants and the product term table for the quaternion rotate unit.
// Depends on nothing; used by quaternion_rotate_normalize_unit and its checker.
package qrn_pkg;

	localparam int FRAC_BITS = 14;
	localparam int QW = 16;
	localparam int PW = 34;
	localparam int MW = 33;
	localparam int QB = FRAC_BITS + 2;
	localparam int DW = 32 + QB;
	localparam int CW = 5;

	localparam logic signed [QW-1:0] ONE_Q =
		((64'sd1 <<< FRAC_BITS) > 64'sd32767) ? 16'sd32767 : QW'(64'sd1 <<< FRAC_BITS);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_ROTATE = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL   = 7'b0000010,
		ST_ABS   = 7'b0000100,
		ST_ALIGN = 7'b0001000,
		ST_SQ    = 7'b0010000,
		ST_SQRT  = 7'b0100000,
		ST_DIV   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic       neg;
		logic [1:0] comp;
		logic [1:0] ai;
		logic [1:0] qi;
	} term_t;

	function automatic term_t term(input logic [3:0] idx);
		term_t t;
		t.comp = idx[3:2];
		unique case (idx)
			4'd0:  begin t.neg = 1'b0; t.ai = 2'd0; t.qi = 2'd0; end
			4'd1:  begin t.neg = 1'b1; t.ai = 2'd1; t.qi = 2'd1; end
			4'd2:  begin t.neg = 1'b1; t.ai = 2'd2; t.qi = 2'd2; end
			4'd3:  begin t.neg = 1'b1; t.ai = 2'd3; t.qi = 2'd3; end
			4'd4:  begin t.neg = 1'b0; t.ai = 2'd0; t.qi = 2'd1; end
			4'd5:  begin t.neg = 1'b0; t.ai = 2'd1; t.qi = 2'd0; end
			4'd6:  begin t.neg = 1'b0; t.ai = 2'd2; t.qi = 2'd3; end
			4'd7:  begin t.neg = 1'b1; t.ai = 2'd3; t.qi = 2'd2; end
			4'd8:  begin t.neg = 1'b0; t.ai = 2'd0; t.qi = 2'd2; end
			4'd9:  begin t.neg = 1'b0; t.ai = 2'd2; t.qi = 2'd0; end
			4'd10: begin t.neg = 1'b0; t.ai = 2'd3; t.qi = 2'd1; end
			4'd11: begin t.neg = 1'b1; t.ai = 2'd1; t.qi = 2'd3; end
			4'd12: begin t.neg = 1'b0; t.ai = 2'd0; t.qi = 2'd3; end
			4'd13: begin t.neg = 1'b0; t.ai = 2'd3; t.qi = 2'd0; end
			4'd14: begin t.neg = 1'b0; t.ai = 2'd1; t.qi = 2'd2; end
			default: begin t.neg = 1'b1; t.ai = 2'd2; t.qi = 2'd1; end
		endcase
		return t;
	endfunction

endpackage

// ===== hw/rtl/quaternion_rotate_normalize_unit.sv =====
// Quaternion orientation keeper: Hamilton product, range alignment, square root and division.
// Depends on qrn_pkg; a 16x16 multiplier for the product terms, a 31-bit squarer, separate
// compare/subtract logic for the square root and the division, and a sequencer. A load raises
// the output after its input transfer, a rotate with a zero product after the product terms,
// and any other rotate after the product terms, alignment, the squares, the bit-serial square
// root and the restoring divisions. One item is in work at a time. Reset clears the orientation.
module quaternion_rotate_normalize_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // in_w, in_x, in_y, in_z
	input  logic [0:0]  s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // out_w, out_x, out_y, out_z
	output logic [0:0]  m_tuser   // zero_norm
);

	qrn_pkg::state_t state_q;
	logic [qrn_pkg::CW-1:0] cnt_q;
	logic [1:0] ci_q;
	logic done_q;
	logic flag_q;

	logic signed [qrn_pkg::QW-1:0] a_q [4];
	logic signed [qrn_pkg::QW-1:0] ori_q [4];
	logic signed [qrn_pkg::PW-1:0] p_q [4];
	logic [qrn_pkg::MW-1:0] m_q [4];
	logic [3:0] neg_q;

	logic signed [31:0] prod_q;
	qrn_pkg::term_t tag_q;
	logic [61:0] sqp_q;
	logic [63:0] s_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [qrn_pkg::DW-1:0] rem_q;
	logic [qrn_pkg::DW-1:0] dsh_q;
	logic [qrn_pkg::QB-1:0] quo_q;
	logic div_init_q;

	qrn_pkg::term_t tcur;
	logic hi, lo, zero;
	logic [63:0] rt;
	logic ge;
	logic [qrn_pkg::QB-1:0] quo_n;
	logic signed [qrn_pkg::QB:0] sv;
	logic signed [qrn_pkg::QW-1:0] sat_v;

	assign s_tready = (state_q == qrn_pkg::ST_IDLE) && !done_q;
	assign tcur = qrn_pkg::term(cnt_q[3:0]);

	always_comb begin
		hi = 1'b0;
		lo = 1'b1;
		zero = 1'b1;
		for (int i = 0; i < 4; i++) begin
			hi = hi | (|m_q[i][qrn_pkg::MW-1:31]);
			lo = lo & ~(|m_q[i][qrn_pkg::MW-1:30]);
			zero = zero & (p_q[i] == '0);
		end
		rt = r_q + bit_q;
		ge = rem_q >= dsh_q;
		quo_n = {quo_q[qrn_pkg::QB-2:0], ge};
		sv = neg_q[ci_q] ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
		if (sv > 32767) begin
			sat_v = 16'sd32767;
		end else if (sv < -32768) begin
			sat_v = -16'sd32768;
		end else begin
			sat_v = qrn_pkg::QW'(sv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qrn_pkg::ST_IDLE;
			cnt_q <= '0;
			ci_q <= '0;
			done_q <= 1'b0;
			flag_q <= 1'b0;
			div_init_q <= 1'b0;
			m_tvalid <= 1'b0;
			for (int i = 0; i < 4; i++) ori_q[i] <= '0;
		end else begin
			if (done_q && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
				m_tdata <= {ori_q[3], ori_q[2], ori_q[1], ori_q[0]};
				m_tuser <= flag_q;
				done_q <= 1'b0;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				qrn_pkg::ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						for (int i = 0; i < 4; i++) begin
							a_q[i] <= s_tdata[16*i +: 16];
							p_q[i] <= '0;
						end
						flag_q <= 1'b0;
						cnt_q <= '0;
						if (s_tuser[0] == qrn_pkg::OP_LOAD) begin
							for (int i = 0; i < 4; i++) ori_q[i] <= s_tdata[16*i +: 16];
							done_q <= 1'b1;
						end else begin
							state_q <= qrn_pkg::ST_MUL;
						end
					end
				end
				qrn_pkg::ST_MUL: begin
					if (cnt_q != '0) begin
						if (tag_q.neg) p_q[tag_q.comp] <= p_q[tag_q.comp] - qrn_pkg::PW'(prod_q);
						else p_q[tag_q.comp] <= p_q[tag_q.comp] + qrn_pkg::PW'(prod_q);
					end
					if (cnt_q[4]) begin
						state_q <= qrn_pkg::ST_ABS;
					end else begin
						prod_q <= a_q[tcur.ai] * ori_q[tcur.qi];
						tag_q <= tcur;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				qrn_pkg::ST_ABS: begin
					for (int i = 0; i < 4; i++) begin
						neg_q[i] <= p_q[i][qrn_pkg::PW-1];
						m_q[i] <= p_q[i][qrn_pkg::PW-1] ? qrn_pkg::MW'(-p_q[i])
							: qrn_pkg::MW'(p_q[i]);
					end
					if (zero) begin
						ori_q[0] <= qrn_pkg::ONE_Q;
						for (int i = 1; i < 4; i++) ori_q[i] <= '0;
						flag_q <= 1'b1;
						done_q <= 1'b1;
						state_q <= qrn_pkg::ST_IDLE;
					end else begin
						state_q <= qrn_pkg::ST_ALIGN;
					end
				end
				qrn_pkg::ST_ALIGN: begin
					if (hi) begin
						for (int i = 0; i < 4; i++) m_q[i] <= m_q[i] >> 1;
					end else if (lo) begin
						for (int i = 0; i < 4; i++) m_q[i] <= m_q[i] << 1;
					end else begin
						cnt_q <= '0;
						s_q <= '0;
						state_q <= qrn_pkg::ST_SQ;
					end
				end
				qrn_pkg::ST_SQ: begin
					if (cnt_q != '0) s_q <= s_q + 64'(sqp_q);
					if (cnt_q == qrn_pkg::CW'(4)) begin
						cnt_q <= '0;
						r_q <= '0;
						bit_q <= 64'd1 << 62;
						state_q <= qrn_pkg::ST_SQRT;
					end else begin
						sqp_q <= m_q[cnt_q[1:0]][30:0] * m_q[cnt_q[1:0]][30:0];
						cnt_q <= cnt_q + 1'b1;
					end
				end
				qrn_pkg::ST_SQRT: begin
					if (s_q >= rt) begin
						s_q <= s_q - rt;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == qrn_pkg::CW'(31)) begin
						ci_q <= '0;
						div_init_q <= 1'b1;
						state_q <= qrn_pkg::ST_DIV;
					end
				end
				qrn_pkg::ST_DIV: begin
					if (div_init_q) begin
						rem_q <= (qrn_pkg::DW'(m_q[ci_q][30:0]) << qrn_pkg::FRAC_BITS)
							+ qrn_pkg::DW'(r_q[31:1]);
						dsh_q <= qrn_pkg::DW'(r_q[31:0]) << (qrn_pkg::QB - 1);
						quo_q <= '0;
						cnt_q <= '0;
						div_init_q <= 1'b0;
					end else begin
						if (ge) rem_q <= rem_q - dsh_q;
						quo_q <= quo_n;
						dsh_q <= dsh_q >> 1;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == qrn_pkg::CW'(qrn_pkg::QB - 1)) begin
							ori_q[ci_q] <= sat_v;
							ci_q <= ci_q + 1'b1;
							div_init_q <= (ci_q != 2'd3);
							if (ci_q == 2'd3) begin
								done_q <= 1'b1;
								state_q <= qrn_pkg::ST_IDLE;
							end
						end
					end
				end
				default: state_q <= qrn_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/qrn_checker.sv =====
// Port-level checks for quaternion_rotate_normalize_unit and the bind that attaches them.
// Depends on qrn_pkg for the identity value.
module qrn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [0:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transfer dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == {48'd0, qrn_pkg::ONE_Q})
		else $error("zero norm flagged without identity result");

endmodule

bind quaternion_rotate_normalize_unit qrn_checker u_qrn_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
